@@ design/ceu_pkg.sv @@
// Shared types and constants of the C escape decoder.
package ceu_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_ESC  = 3'd1,
    MODE_HEX  = 3'd2,
    MODE_U4   = 3'd3,
    MODE_U8   = 3'd4,
    MODE_OCT  = 3'd5,
    MODE_DROP = 3'd6
  } mode_e;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_UNFINISHED = 3'd1;
  localparam logic [2:0] ST_RANGE      = 3'd2;
  localparam logic [2:0] ST_FEW_DIGITS = 3'd3;
  localparam logic [2:0] ST_SURROGATE  = 3'd4;

  // Work for the back end: up to four data bytes, then an optional closing item.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            has_end;
    logic [2:0]      status;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       end_of_string;
  } item_t;

endpackage

@@ design/ceu_fifo.sv @@
// Small register FIFO used for the command queue and the result queue.
module ceu_fifo
  import ceu_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ design/ceu_front.sv @@
// Front end: scans escape syntax per input byte and builds at most one command per byte.
module ceu_front
  import ceu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       final_byte_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o
);

  localparam logic [7:0]  CH_BSL   = 8'h5C;
  localparam logic [7:0]  CH_X     = 8'h78;
  localparam logic [7:0]  CH_U_LC  = 8'h75;
  localparam logic [7:0]  CH_U_UC  = 8'h55;
  localparam logic [31:0] CP_MAX   = 32'h0010_FFFF;
  localparam logic [31:0] SUR_LO   = 32'h0000_D800;
  localparam logic [31:0] SUR_HI   = 32'h0000_DFFF;
  localparam logic [31:0] CP_ASCII = 32'h0000_0080;

  mode_e       mode_q, mode_d, t_mode;
  logic [31:0] value_q, value_d, t_value;
  logic [3:0]  count_q, count_d, t_count;

  logic [3:0][7:0] t_bytes;
  logic [2:0]      t_nb;
  logic            t_fail;
  logic [2:0]      t_status;

  logic        is_dec, is_alpha, hex_ok, is_oct, hex_over, uni_done;
  logic [7:0]  lc_byte, esc_byte;
  logic [3:0]  hex_d;
  logic [11:0] hex_acc;
  logic [8:0]  oct_acc;
  logic [31:0] uni_acc;
  logic [34:0] utf8;

  // {count, bytes} of the UTF-8 form of a code point in 0x80..0x10FFFF
  function automatic logic [34:0] utf8_enc(input logic [20:0] v);
    logic [3:0][7:0] b;
    logic [2:0]      n;
    b = '0;
    if (v >= 21'h10000) begin
      b[0] = 8'hF0 | {5'b0, v[20:18]};
      b[1] = 8'h80 | {2'b0, v[17:12]};
      b[2] = 8'h80 | {2'b0, v[11:6]};
      b[3] = 8'h80 | {2'b0, v[5:0]};
      n    = 3'd4;
    end else if (v >= 21'h800) begin
      b[0] = 8'hE0 | {4'b0, v[15:12]};
      b[1] = 8'h80 | {2'b0, v[11:6]};
      b[2] = 8'h80 | {2'b0, v[5:0]};
      n    = 3'd3;
    end else begin
      b[0] = 8'hC0 | {3'b0, v[10:6]};
      b[1] = 8'h80 | {2'b0, v[5:0]};
      n    = 3'd2;
    end
    return {n, b};
  endfunction

  assign lc_byte  = in_byte_i | 8'h20;
  assign is_dec   = (in_byte_i >= 8'h30) && (in_byte_i <= 8'h39);
  assign is_alpha = (lc_byte >= 8'h61) && (lc_byte <= 8'h66);
  assign hex_ok   = is_dec || is_alpha;
  assign hex_d    = is_dec ? in_byte_i[3:0] : lc_byte[3:0] + 4'd9;
  assign is_oct   = (in_byte_i[7:3] == 5'b00110);
  assign hex_acc  = {value_q[7:0], 4'h0} + {8'h0, hex_d};
  assign hex_over = (hex_acc[11:8] != 4'h0);
  assign oct_acc  = {value_q[5:0], 3'b000} + {6'b0, in_byte_i[2:0]};
  assign uni_acc  = {value_q[27:0], hex_d};
  assign uni_done = (mode_q == MODE_U4) ? (count_q == 4'd3) : (count_q == 4'd7);
  assign utf8     = utf8_enc(uni_acc[20:0]);

  always_comb begin
    unique case (in_byte_i)
      8'h61:   esc_byte = 8'd7;
      8'h62:   esc_byte = 8'd8;
      8'h74:   esc_byte = 8'd9;
      8'h6E:   esc_byte = 8'd10;
      8'h76:   esc_byte = 8'd11;
      8'h66:   esc_byte = 8'd12;
      8'h72:   esc_byte = 8'd13;
      default: esc_byte = in_byte_i;
    endcase
  end

  // Effect of the byte itself, before any end-of-string handling.
  always_comb begin : classify
    t_mode   = mode_q;
    t_value  = value_q;
    t_count  = count_q;
    t_bytes  = '0;
    t_nb     = 3'd0;
    t_fail   = 1'b0;
    t_status = ST_OK;
    unique case (mode_q)
      MODE_DROP: begin
      end
      MODE_ESC: begin
        t_mode  = MODE_IDLE;
        t_value = '0;
        t_count = '0;
        if (in_byte_i == CH_X) begin
          t_mode = MODE_HEX;
        end else if (in_byte_i == CH_U_LC) begin
          t_mode = MODE_U4;
        end else if (in_byte_i == CH_U_UC) begin
          t_mode = MODE_U8;
        end else if (is_oct) begin
          t_mode  = MODE_OCT;
          t_value = {29'b0, in_byte_i[2:0]};
          t_count = 4'd1;
        end else begin
          t_bytes[0] = esc_byte;
          t_nb       = 3'd1;
        end
      end
      MODE_HEX: begin
        if (hex_ok) begin
          t_value = {20'b0, hex_acc};
          t_count = (count_q != 4'hF) ? count_q + 4'd1 : count_q;
          if (hex_over) begin
            t_fail   = 1'b1;
            t_status = ST_RANGE;
          end
        end else if (count_q == 4'd0) begin
          t_fail   = 1'b1;
          t_status = ST_FEW_DIGITS;
        end else begin
          t_bytes[0] = value_q[7:0];
          if (in_byte_i == CH_BSL) begin
            t_mode = MODE_ESC;
            t_nb   = 3'd1;
          end else begin
            t_mode     = MODE_IDLE;
            t_bytes[1] = in_byte_i;
            t_nb       = 3'd2;
          end
        end
      end
      MODE_U4, MODE_U8: begin
        if (!hex_ok) begin
          t_fail   = 1'b1;
          t_status = ST_FEW_DIGITS;
        end else begin
          t_value = uni_acc;
          t_count = count_q + 4'd1;
          if (uni_done) begin
            t_mode = MODE_IDLE;
            if (uni_acc < CP_ASCII) begin
              t_bytes[0] = uni_acc[7:0];
              t_nb       = 3'd1;
            end else if (uni_acc > CP_MAX) begin
              t_fail   = 1'b1;
              t_status = ST_RANGE;
            end else if (uni_acc >= SUR_LO && uni_acc <= SUR_HI) begin
              t_fail   = 1'b1;
              t_status = ST_SURROGATE;
            end else begin
              t_bytes = utf8[31:0];
              t_nb    = utf8[34:32];
            end
          end
        end
      end
      MODE_OCT: begin
        if (is_oct) begin
          t_value = {23'b0, oct_acc};
          t_count = count_q + 4'd1;
          if (count_q == 4'd2) begin
            t_mode = MODE_IDLE;
            if (oct_acc[8]) begin
              t_fail   = 1'b1;
              t_status = ST_RANGE;
            end else begin
              t_bytes[0] = oct_acc[7:0];
              t_nb       = 3'd1;
            end
          end
        end else begin
          t_bytes[0] = value_q[7:0];
          if (in_byte_i == CH_BSL) begin
            t_mode = MODE_ESC;
            t_nb   = 3'd1;
          end else begin
            t_mode     = MODE_IDLE;
            t_bytes[1] = in_byte_i;
            t_nb       = 3'd2;
          end
        end
      end
      default: begin
        if (in_byte_i == CH_BSL) begin
          t_mode = MODE_ESC;
        end else begin
          t_mode     = MODE_IDLE;
          t_bytes[0] = in_byte_i;
          t_nb       = 3'd1;
        end
      end
    endcase
    if (t_fail) begin
      t_mode = MODE_DROP;
    end
  end

  // Next state; the final byte of a string always returns to idle.
  always_comb begin : next_state
    mode_d  = mode_q;
    value_d = value_q;
    count_d = count_q;
    if (valid_i) begin
      if (final_byte_i) begin
        mode_d  = MODE_IDLE;
        value_d = '0;
        count_d = '0;
      end else begin
        mode_d  = t_mode;
        value_d = t_value;
        count_d = t_count;
      end
    end
  end

  // Command: bytes of this input plus the closing item on an error or when the string ends; nothing while dropping.
  always_comb begin : outputs
    cmd_o.bytes   = t_bytes;
    cmd_o.nbytes  = t_nb;
    cmd_o.has_end = 1'b0;
    cmd_o.status  = ST_OK;
    if (mode_q == MODE_DROP) begin
      cmd_o.nbytes = 3'd0;
    end else if (t_fail) begin
      cmd_o.has_end = 1'b1;
      cmd_o.status  = t_status;
    end else if (final_byte_i) begin
      cmd_o.has_end = 1'b1;
      unique case (t_mode)
        MODE_ESC: cmd_o.status = ST_UNFINISHED;
        MODE_HEX: begin
          if (t_count == 4'd0) begin
            cmd_o.status = ST_FEW_DIGITS;
          end else begin
            cmd_o.bytes[0] = t_value[7:0];
            cmd_o.nbytes   = 3'd1;
          end
        end
        MODE_U4, MODE_U8: cmd_o.status = ST_FEW_DIGITS;
        MODE_OCT: begin
          cmd_o.bytes[0] = t_value[7:0];
          cmd_o.nbytes   = 3'd1;
        end
        default: begin
        end
      endcase
    end
    cmd_valid_o = valid_i && ((cmd_o.nbytes != 3'd0) || cmd_o.has_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      value_q <= '0;
      count_q <= '0;
    end else begin
      mode_q  <= mode_d;
      value_q <= value_d;
      count_q <= count_d;
    end
  end

endmodule

@@ design/ceu_back.sv @@
// Back end: expands each command into result items, one item per cycle while the result queue is not full.
module ceu_back
  import ceu_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cmd_valid_i,
  input  cmd_t  cmd_i,
  output logic  cmd_pop_o,
  output logic  item_push_o,
  output item_t item_o,
  input  logic  item_full_i
);

  logic [2:0] idx_q, idx_d;
  logic [2:0] total;
  logic       is_data, last, emit;

  assign total   = cmd_i.nbytes + {2'b0, cmd_i.has_end};
  assign is_data = (idx_q < cmd_i.nbytes);
  assign last    = (idx_q == total - 3'd1);
  assign emit    = cmd_valid_i && !item_full_i;

  assign item_push_o = emit;
  assign cmd_pop_o   = emit && last;

  always_comb begin
    if (is_data) begin
      item_o.out_byte      = cmd_i.bytes[idx_q[1:0]];
      item_o.byte_valid    = 1'b1;
      item_o.status        = ST_OK;
      item_o.end_of_string = 1'b0;
    end else begin
      item_o.out_byte      = 8'h00;
      item_o.byte_valid    = 1'b0;
      item_o.status        = cmd_i.status;
      item_o.end_of_string = 1'b1;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (emit) begin
      idx_d = last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

@@ design/c_escape_unescaper.sv @@
// Path: each byte's results pass the command queue, then the result queue, before a pop.
// Rate: one byte per cycle while each byte yields at most one result item and the
//   result queue is not full; a byte yielding k items (up to 5) holds the expander
//   until all are out, and the command queue absorbs such bursts until it fills.
// Reset: asynchronous, active low; both queues empty, scanner idle outside escapes.
module c_escape_unescaper
  import ceu_pkg::*;
#(
  parameter int CMD_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       final_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic [2:0] status_o,
  output logic       end_of_string_o
);

  logic  accept;
  logic  cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t  cmd_in, cmd_head;
  logic  item_push, item_full;
  item_t item_in, item_head;

  assign accept = push && !full;
  assign full   = cmd_full;

  ceu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .in_byte_i    (in_byte_i),
    .final_byte_i (final_byte_i),
    .cmd_valid_o  (cmd_push),
    .cmd_o        (cmd_in)
  );

  ceu_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty)
  );

  ceu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .item_push_o (item_push),
    .item_o      (item_in),
    .item_full_i (item_full)
  );

  ceu_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (item_push),
    .wdata_i (item_in),
    .full_o  (item_full),
    .pop_i   (pop),
    .rdata_o (item_head),
    .empty_o (empty)
  );

  assign out_byte_o      = item_head.out_byte;
  assign byte_valid_o    = item_head.byte_valid;
  assign status_o        = item_head.status;
  assign end_of_string_o = item_head.end_of_string;

endmodule

@@ design/ceu_checker.sv @@
// Port-level checks of the C escape decoder and their binding to the top level.
module ceu_checker
  import ceu_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty_i,
  input logic       pop_i,
  input logic [7:0] out_byte_i,
  input logic       byte_valid_i,
  input logic [2:0] status_i,
  input logic       end_of_string_i
);

  // A waiting item that is not taken stays on the ports.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !pop_i) |=> (!empty_i && $stable(out_byte_i) && $stable(byte_valid_i)
                              && $stable(status_i) && $stable(end_of_string_i)))
    else $error("waiting result item changed before it was taken");

  // Data items carry no status and never close a string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && byte_valid_i) |-> (status_i == ST_OK && !end_of_string_i))
    else $error("data item with status or end mark");

  // An item without a byte is always the closing item, with a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !byte_valid_i) |-> (end_of_string_i && out_byte_i == 8'h00))
    else $error("item without byte that does not close the string");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (status_i <= ST_SURROGATE))
    else $error("status code out of range");

  // Reset leaves no result waiting.
  assert property (@(posedge clk_i) !rst_ni |=> empty_i)
    else $error("result waiting right after reset");

endmodule

bind c_escape_unescaper ceu_checker u_ceu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty_i         (empty),
  .pop_i           (pop),
  .out_byte_i      (out_byte_o),
  .byte_valid_i    (byte_valid_o),
  .status_i        (status_o),
  .end_of_string_i (end_of_string_o)
);

@@ tb/c_escape_unescaper_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the C escape decoder: random and directed strings, item by item.
module c_escape_unescaper_tb
  import ceu_pkg::*;
();

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int STREAM_LEN  = 420;

  // Predicts the decoded items of each accepted byte and checks popped items in order.
  class unescape_checker;
    mode_e       scan;
    logic [31:0] acc;
    logic [3:0]  ndig;
    item_t       pending_items[$];
    int          errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      scan = MODE_IDLE;
      acc  = 32'h0;
      ndig = 4'h0;
    endfunction

    function void emit(logic [7:0] b, logic v, logic [2:0] st, logic eos);
      item_t it;
      it.out_byte      = b;
      it.byte_valid    = v;
      it.status        = st;
      it.end_of_string = eos;
      pending_items.push_back(it);
    endfunction

    function void emit_byte(logic [7:0] b);
      emit(b, 1'b1, ST_OK, 1'b0);
    endfunction

    function void abort(logic [2:0] st);
      scan = MODE_DROP;
      emit(8'h00, 1'b0, st, 1'b1);
    endfunction

    function int hex_value(logic [7:0] b);
      logic [7:0] l;
      l = b | 8'h20;
      if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
      if (l >= 8'h61 && l <= 8'h66) return int'(l - 8'h61) + 10;
      return -1;
    endfunction

    function void emit_utf8(logic [31:0] v);
      scan = MODE_IDLE;
      if (v < 32'd128) begin
        emit_byte(v[7:0]);
      end else if (v > 32'h0010_FFFF) begin
        abort(ST_RANGE);
      end else if (v >= 32'h0000_D800 && v <= 32'h0000_DFFF) begin
        abort(ST_SURROGATE);
      end else begin
        if (v >= 32'h0001_0000) begin
          emit_byte(8'hF0 | {2'b00, v[23:18]});
          emit_byte(8'h80 | {2'b00, v[17:12]});
        end else if (v >= 32'h0000_0800) begin
          emit_byte(8'hE0 | {2'b00, v[17:12]});
        end
        emit_byte(((v < 32'h0000_0800) ? 8'hC0 : 8'h80) | {2'b00, v[11:6]});
        emit_byte(8'h80 | {2'b00, v[5:0]});
      end
    endfunction

    function void plain(logic [7:0] b);
      if (b == CH_BSLASH) begin
        scan = MODE_ESC;
      end else begin
        scan = MODE_IDLE;
        emit_byte(b);
      end
    endfunction

    function void after_backslash(logic [7:0] b);
      logic [7:0] m;
      clear_state();
      m = b;
      case (b)
        8'h61: m = 8'h07;  // a
        8'h62: m = 8'h08;  // b
        8'h74: m = 8'h09;  // t
        8'h6E: m = 8'h0A;  // n
        8'h76: m = 8'h0B;  // v
        8'h66: m = 8'h0C;  // f
        8'h72: m = 8'h0D;  // r
        8'h78: begin
          scan = MODE_HEX;
          return;
        end
        8'h75: begin
          scan = MODE_U4;
          return;
        end
        8'h55: begin
          scan = MODE_U8;
          return;
        end
        default: begin
          if (b >= 8'h30 && b <= 8'h37) begin
            scan = MODE_OCT;
            acc  = {29'h0, b[2:0]};
            ndig = 4'd1;
            return;
          end
        end
      endcase
      // unknown escapes pass the byte through once
      emit_byte(m);
    endfunction

    function void decode_byte(logic [7:0] b);
      int         d;
      logic [3:0] need;
      case (scan)
        MODE_ESC: after_backslash(b);
        MODE_HEX: begin
          d = hex_value(b);
          if (d >= 0) begin
            acc = (acc << 4) | 32'(d);
            if (ndig < 4'd15) ndig = ndig + 4'd1;
            if (acc > 32'd255) abort(ST_RANGE);
          end else if (ndig == 4'd0) begin
            abort(ST_FEW_DIGITS);
          end else begin
            emit_byte(acc[7:0]);
            plain(b);
          end
        end
        MODE_U4, MODE_U8: begin
          need = (scan == MODE_U4) ? 4'd4 : 4'd8;
          d = hex_value(b);
          if (d < 0) begin
            abort(ST_FEW_DIGITS);
          end else begin
            acc  = (acc << 4) | 32'(d);
            ndig = ndig + 4'd1;
            if (ndig >= need) emit_utf8(acc);
          end
        end
        MODE_OCT: begin
          if (b >= 8'h30 && b <= 8'h37) begin
            acc  = (acc << 3) | {29'h0, b[2:0]};
            ndig = ndig + 4'd1;
            if (ndig >= 4'd3) begin
              scan = MODE_IDLE;
              if (acc > 32'd255) abort(ST_RANGE);
              else emit_byte(acc[7:0]);
            end
          end else begin
            emit_byte(acc[7:0]);
            plain(b);
          end
        end
        default: plain(b);
      endcase
    endfunction

    function void finish_string();
      case (scan)
        MODE_ESC: begin
          abort(ST_UNFINISHED);
          return;
        end
        MODE_HEX: begin
          if (ndig == 4'd0) begin
            abort(ST_FEW_DIGITS);
            return;
          end
          emit_byte(acc[7:0]);
        end
        MODE_U4, MODE_U8: begin
          abort(ST_FEW_DIGITS);
          return;
        end
        MODE_OCT: emit_byte(acc[7:0]);
        default: ;
      endcase
      scan = MODE_IDLE;
      emit(8'h00, 1'b0, ST_OK, 1'b1);
    endfunction

    function void take_input(logic [7:0] b, logic last);
      // after an error everything up to the final byte is swallowed
      if (scan == MODE_DROP) begin
        if (last) clear_state();
        return;
      end
      decode_byte(b);
      if (scan == MODE_DROP) begin
        if (last) clear_state();
        return;
      end
      if (last) begin
        finish_string();
        clear_state();
      end
    endfunction

    function void check_output(item_t got);
      item_t want;
      if (pending_items.size() == 0) begin
        errors++;
        $display("%0t: unexpected item byte=%02h valid=%b status=%0d end=%b", $time,
                 got.out_byte, got.byte_valid, got.status, got.end_of_string);
        return;
      end
      want = pending_items.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch: expected byte=%02h valid=%b status=%0d end=%b,",
                 $time, want.out_byte, want.byte_valid, want.status, want.end_of_string,
                 " got byte=%02h valid=%b status=%0d end=%b",
                 got.out_byte, got.byte_valid, got.status, got.end_of_string);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] in_byte_i;
  logic       final_byte_i;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic [2:0] status_o;
  logic       end_of_string_o;

  unescape_checker sb = new();

  logic [8:0] escaped_stream[$];  // {final, byte}
  logic [7:0] simple_escapes [0:10] = '{8'h22, 8'h27, 8'h3F, 8'h5C, 8'h61, 8'h62,
                                        8'h74, 8'h6E, 8'h76, 8'h66, 8'h72};
  int sender_idle;
  int recv_stall;
  int sent_items;
  bit hold_done;

  c_escape_unescaper uut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .in_byte_i,
    .final_byte_i,
    .empty,
    .pop,
    .out_byte_o,
    .byte_valid_o,
    .status_o,
    .end_of_string_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) sb.take_input(in_byte_i, final_byte_i);
      if (pop && !empty) begin
        sb.check_output(item_t'({out_byte_o, byte_valid_o, status_o, end_of_string_o}));
      end
    end
  end

  function automatic void put_byte(logic [7:0] b);
    escaped_stream.push_back({1'b0, b});
  endfunction

  function automatic void mark_final();
    escaped_stream[escaped_stream.size() - 1][8] = 1'b1;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    logic [7:0] c;
    c = (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
    if (n >= 4'd10 && $urandom_range(0, 1) == 1) c = c | 8'h20;
    return c;
  endfunction

  function automatic void put_hex_digits(logic [31:0] v, int total, int keep);
    for (int i = total - 1; i >= total - keep; i--) put_byte(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic logic [31:0] pick_code_point(bit wide);
    int cat;
    cat = $urandom_range(0, wide ? 5 : 3);
    case (cat)
      0: return 32'($urandom_range(0, 127));
      1: return 32'($urandom_range(128, 32'h7FF));
      2: return 32'($urandom_range(32'h800, 32'hFFFF));
      3: return 32'($urandom_range(32'hD800, 32'hDFFF));
      4: return 32'($urandom_range(32'h10000, 32'h10FFFF));
      default: return 32'($urandom_range(32'h110000, 32'hFFFF_FFFF));
    endcase
  endfunction

  function automatic void add_piece();
    logic [7:0]  b;
    logic [31:0] cp;
    int          total;
    int          keep;
    int          nd;
    case ($urandom_range(0, 9))
      0, 1: begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_BSLASH) b = 8'h41;
        put_byte(b);
      end
      2: begin
        put_byte(CH_BSLASH);
        put_byte(simple_escapes[$urandom_range(0, 10)]);
      end
      3: begin
        put_byte(CH_BSLASH);
        put_byte(8'($urandom_range(0, 255)));
      end
      4: begin
        put_byte(CH_BSLASH);
        put_byte(8'h78);
        repeat ($urandom_range(0, 2)) put_byte(8'h30);
        nd = $urandom_range(0, 3);
        repeat (nd) put_byte(hex_char(4'($urandom_range(0, 15))));
      end
      5: begin
        put_byte(CH_BSLASH);
        repeat ($urandom_range(1, 3)) put_byte(8'h30 + 8'($urandom_range(0, 7)));
      end
      6, 7, 8: begin
        total = ($urandom_range(0, 2) == 0) ? 8 : 4;
        put_byte(CH_BSLASH);
        put_byte((total == 8) ? 8'h55 : 8'h75);
        cp = pick_code_point(total == 8);
        // now and then the digit run is cut short
        keep = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : total;
        put_hex_digits(cp, total, keep);
      end
      default: put_byte(($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00);
    endcase
  endfunction

  function automatic void add_string();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 5)) add_piece();
      if ($urandom_range(0, 15) == 0) put_byte(CH_BSLASH);
    end
    mark_final();
  endfunction

  function automatic void add_directed();
    // zero byte alone as a whole string
    put_byte(8'h00);
    mark_final();
    // top byte, known and unknown escapes, bare \x at the end
    put_byte(8'hFF);
    put_byte(CH_BSLASH); put_byte(8'h6E);
    put_byte(CH_BSLASH); put_byte(8'h71);
    put_byte(CH_BSLASH); put_byte(8'h38);
    put_byte(CH_BSLASH); put_byte(CH_BSLASH);
    put_byte(CH_BSLASH); put_byte(8'h78);
    mark_final();
    // four-byte UTF-8 sequence
    put_byte(CH_BSLASH); put_byte(8'h55);
    put_hex_digits(32'h0001_F600, 8, 8);
    mark_final();
    // octal out of range on the final byte
    put_byte(CH_BSLASH); put_byte(8'h34); put_byte(8'h30); put_byte(8'h30);
    mark_final();
    // lone backslash
    put_byte(CH_BSLASH);
    mark_final();
  endfunction

  task automatic send_stream();
    logic [8:0] it;
    int         total;
    total = escaped_stream.size();
    for (int i = 0; i < total; i++) begin
      it = escaped_stream[i];
      case (i * 4 / total)
        0: begin sender_idle = 0;  recv_stall = 0;  end
        1: begin sender_idle = 45; recv_stall = 0;  end
        2: begin sender_idle = 0;  recv_stall = 45; end
        default: begin sender_idle = 33; recv_stall = 33; end
      endcase
      while ($urandom_range(0, 99) < sender_idle) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
      push         <= 1'b1;
      in_byte_i    <= it[7:0];
      final_byte_i <= it[8];
      do @(posedge clk_i); while (full);
      sent_items++;
    end
    push <= 1'b0;
  endtask

  task automatic drain_results();
    forever begin
      if (!hold_done && sent_items >= HOLD_AT) begin
        // long hold-off so the queues fill and the input stalls
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_stall);
        @(posedge clk_i);
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    in_byte_i    = 8'h00;
    final_byte_i = 1'b0;
    sender_idle  = 0;
    recv_stall   = 0;
    sent_items   = 0;
    hold_done    = 1'b0;
    add_directed();
    while (escaped_stream.size() < STREAM_LEN) add_string();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      drain_results();
    join_none
    send_stream();
    @(posedge clk_i);
    while (sb.pending_items.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_items.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/ceu_pkg.sv
design/ceu_fifo.sv
design/ceu_front.sv
design/ceu_back.sv
design/c_escape_unescaper.sv
design/ceu_checker.sv
tb/c_escape_unescaper_tb.sv
